// ===== src/fpcm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpcm_pkg
// Shared constants for the float to PCM sample converter.
// ----------------------------------------------------------------------------
package fpcm_pkg;

  localparam int FloatW = 32;
  localparam int PcmW   = 32;
  localparam int CountW = 3;
  localparam int FmtW   = 2;

  // Output format codes.
  localparam logic [FmtW-1:0] FMT_S16 = 2'd0;
  localparam logic [FmtW-1:0] FMT_S24 = 2'd1;
  localparam logic [FmtW-1:0] FMT_S32 = 2'd2;

  // Byte counts per format.
  localparam logic [CountW-1:0] BYTES_S16 = 3'd2;
  localparam logic [CountW-1:0] BYTES_S24 = 3'd3;
  localparam logic [CountW-1:0] BYTES_S32 = 3'd4;

  localparam logic [FmtW-1:0] FMT_RESET = FMT_S16;

endpackage : fpcm_pkg
`default_nettype wire

// ===== src/fpcm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpcm_in_if / fpcm_out_if
// Valid/ready channels for float samples and PCM results.
// ----------------------------------------------------------------------------
interface fpcm_in_if import fpcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FloatW-1:0] float_sample;
  modport source (output valid, output float_sample, input ready);
  modport sink   (input valid, input float_sample, output ready);
endinterface : fpcm_in_if

interface fpcm_out_if import fpcm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic signed [PcmW-1:0] pcm_word;
  logic [CountW-1:0]   byte_count;
  modport source (output valid, output pcm_word, output byte_count, input ready);
  modport sink   (input valid, input pcm_word, input byte_count, output ready);
endinterface : fpcm_out_if
`default_nettype wire

// ===== src/float_to_pcm_sample_converter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// float_to_pcm_sample_converter_unit
// Converts IEEE single-precision samples to signed PCM words.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | float_sample[31:0]
//  out_    | out | pcm_word[31:0] signed, byte_count[2:0]
//  cfg_    | in  | sample_format[1:0], write enable
// One sample per cycle while the result is not stalled.
// The input register and the result register form a two-stage pipeline.
// A stalled result holds; the input stage still fills when the result moves.
// Reset is synchronous, active low, and selects the 16-bit format.
module float_to_pcm_sample_converter_unit import fpcm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [FmtW-1:0] cfg_wdata,
  fpcm_in_if.sink              in_ch,
  fpcm_out_if.source           out_ch
);

  logic [FmtW-1:0]        fmt_r;
  logic                   s1_valid_r;
  logic [FloatW-1:0]      s1_data_r;
  logic                   out_valid_r;
  logic signed [PcmW-1:0] out_word_r;
  logic [CountW-1:0]      out_count_r;
  logic signed [PcmW-1:0] word_nxt;
  logic [CountW-1:0]      count_nxt;
  logic                   s1_adv;

  // Pipeline advance control.
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  fpcm_core u_core (
    .float_sample (s1_data_r),
    .fmt          (fmt_r),
    .pcm_word     (word_nxt),
    .byte_count   (count_nxt)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) fmt_r <= FMT_RESET;
    else if (cfg_we) fmt_r <= cfg_wdata;
  end

  // Input and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (s1_adv) out_valid_r <= s1_valid_r;
    end
    if (in_ch.ready && in_ch.valid) s1_data_r <= in_ch.float_sample;
    if (s1_adv && s1_valid_r) begin
      out_word_r  <= word_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pcm_word   = out_word_r;
  assign out_ch.byte_count = out_count_r;

endmodule : float_to_pcm_sample_converter_unit
`default_nettype wire

// ===== src/fpcm_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpcm_core
// Combinational conversion of one float sample to a PCM word.
// ----------------------------------------------------------------------------
module fpcm_core import fpcm_pkg::*; (
  input  wire logic [FloatW-1:0]   float_sample,
  input  wire logic [FmtW-1:0]     fmt,
  output logic signed [PcmW-1:0]   pcm_word,
  output logic [CountW-1:0]        byte_count
);

  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic        is_nan;
  logic        full;
  logic        neg;
  logic [23:0] mant;
  logic [4:0]  nbits;
  logic [47:0] prod;
  logic [47:0] shifted;
  logic [5:0]  msb;
  logic [5:0]  drop;
  logic [47:0] keep_mask;
  logic [47:0] kept;
  logic [47:0] rem;
  logic [47:0] half;
  logic [48:0] rounded;
  logic [8:0]  shr;
  logic [31:0] mag_full;

  always_comb begin
    sgn    = float_sample[31];
    ex     = float_sample[30:23];
    fr     = float_sample[22:0];
    is_nan = (ex == 8'hFF) && (fr != 23'd0);
    // Clamp: NaN and anything at or beyond one goes to full scale.
    full   = is_nan || (ex >= 8'd127);
    neg    = sgn && !is_nan;
    mant   = {(ex != 8'd0), fr};
    // Scale is 2^n - 1 for n = 15, 23; 32-bit scale is 2^31 exactly.
    unique case (fmt)
      FMT_S16: begin nbits = 5'd15; byte_count = BYTES_S16; end
      FMT_S24: begin nbits = 5'd23; byte_count = BYTES_S24; end
      default: begin nbits = 5'd31; byte_count = BYTES_S32; end
    endcase
    // Exact product of the significand and the scale. The 32-bit product is
    // held as mant * 2^23 so that it fits, and is shifted eight bits less below.
    if (nbits == 5'd31) prod = {1'b0, mant, 23'd0};
    else prod = ({24'd0, mant} << nbits) - {24'd0, mant};
    // Round exact product to 24 significant bits, nearest even.
    msb = 6'd0;
    for (int i = 0; i < 48; i++) if (prod[i]) msb = 6'(i);
    drop = (msb > 6'd23) ? msb - 6'd23 : 6'd0;
    keep_mask = ~((48'd1 << drop) - 48'd1);
    kept = prod & keep_mask;
    rem  = prod & ~keep_mask;
    half = (drop == 6'd0) ? 48'd0 : (48'd1 << (drop - 6'd1));
    rounded = {1'b0, kept};
    if (drop != 6'd0 && (rem > half || (rem == half && kept[drop])))
      rounded = {1'b0, kept} + {1'b0, (48'd1 << drop)};
    // Value = rounded * 2^(e-150), or 2^(e-142) for the 32-bit format, where e is effective exponent; truncate.
    shr = ((nbits == 5'd31) ? 9'd142 : 9'd150) - ((ex == 8'd0) ? 9'd1 : {1'b0, ex});
    shifted = (shr > 9'd48) ? 48'd0 : 48'(rounded >> shr);
    // Full scale: 2^n - 1, or 2^31 for the 32-bit format.
    mag_full = full ? ((nbits == 5'd31) ? 32'h8000_0000 : ((32'd1 << nbits) - 32'd1))
                    : 32'(shifted);
    // Positive 2^31 does not fit and saturates; negative 2^31 is exact.
    if (!neg && mag_full[31]) mag_full = 32'h7FFF_FFFF;
    pcm_word = neg ? $signed(-mag_full) : $signed(mag_full);
  end

endmodule : fpcm_core
`default_nettype wire

// ===== src/fpcm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpcm_checker
// Port-level checks for the float to PCM converter.
// ----------------------------------------------------------------------------
module fpcm_checker import fpcm_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [PcmW-1:0]   out_word,
  input wire logic [CountW-1:0] out_count
);

  // A stalled result stays valid and holds its PCM word.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  // Byte count is a legal value whenever the output is valid.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count == BYTES_S16 || out_count == BYTES_S24 ||
                   out_count == BYTES_S32))
    else $error("illegal byte count");

  // A transfer on the input yields a result if the output is unstalled.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 1'b1 |-> out_valid)
    else $error("lost sample");

  // Input is ready whenever the output side accepts.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule : fpcm_checker

bind float_to_pcm_sample_converter_unit fpcm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.pcm_word),
  .out_count (out_ch.byte_count)
);
`default_nettype wire
